// File: rtl/kcl_pkg.sv
package kcl_pkg;

    localparam int PIN_DIGITS = 4;
    localparam int PIN_W      = 8 * PIN_DIGITS;
    localparam int CFG_W      = 32;

    localparam logic [CFG_W-1:0] DEFAULT_PIN_RST = 32'h3132_3334;

    localparam logic [7:0] KEY_CLEAR  = 8'h2A;  // '*'
    localparam logic [7:0] KEY_CHANGE = 8'h23;  // '#'
    localparam logic [7:0] KEY_ZERO   = 8'h30;  // '0'
    localparam logic [7:0] KEY_NINE   = 8'h39;  // '9'

    typedef logic [PIN_W-1:0] t_pin;

    localparam t_pin PIN_ZEROS = {PIN_DIGITS{KEY_ZERO}};
    localparam logic [2:0] CNT_LAST = 3'(PIN_DIGITS - 1);

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_VERIFY = 2'd1,
        MODE_NEWPIN = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        EV_IGNORED   = 4'd0,
        EV_DIGIT     = 4'd1,
        EV_CLEARED   = 4'd2,
        EV_CHANGE    = 4'd3,
        EV_OLD_OK    = 4'd4,
        EV_OLD_WRONG = 4'd5,
        EV_NEW_SAVED = 4'd6,
        EV_RESTORED  = 4'd7,
        EV_OPEN      = 4'd8,
        EV_REJECT    = 4'd9
    } t_event;

    typedef struct packed {
        t_event      event_res;
        logic        lock_open;
        logic [2:0]  digits_entered;
        t_mode       mode_now;
        logic        persist_write;
        logic [31:0] persist_value;
    } t_res;

endpackage

// File: rtl/keypad_code_lock_controller_unit.sv
// Keypad code lock controller.
// Input channel: i_in_valid / o_in_stall carry one ASCII key code per transfer
// on i_key_code. Output channel: o_out_valid / i_out_stall carry one result per
// key: event code, latched lock position, digits held, mode, and the stored PIN
// with a flag that asks for it to be saved.
// Configuration: i_cfg_wr_en with i_cfg_wr_data writes the PIN that the all-zero
// code restores; write it only while no key is in flight.
// Path: a key is held in the input register; its state update then lands in the
// result register, which drives the output.
// Throughput: one key per cycle while the receiver does not stall; the state
// update is a single pass of compare and select logic between the two registers.
// Reset (synchronous, active low) empties both registers, closes the lock,
// returns to normal mode and loads the stored and default PIN with "1234".
// When the receiver stalls, the result holds on the output and the next key
// waits in the input register; o_in_stall rises once both are full.
module keypad_code_lock_controller_unit
    import kcl_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_key_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_event_res,
    output logic        o_lock_open,
    output logic [2:0]  o_digits_entered,
    output logic [1:0]  o_mode_now,
    output logic        o_persist_write,
    output logic [31:0] o_persist_value
);

    logic       r_in_vld;
    logic [7:0] r_in_key;
    logic       r_out_vld;
    t_res       r_out;
    t_res       core_res;
    logic       advance;
    logic       in_take;

    // advance the held key once the result register is free or being drained
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    kcl_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_step        (advance),
        .i_key         (r_in_key),
        .o_res         (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_key <= i_key_code;
        end
        if (advance) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid      = r_out_vld;
    assign o_event_res      = r_out.event_res;
    assign o_lock_open      = r_out.lock_open;
    assign o_digits_entered = r_out.digits_entered;
    assign o_mode_now       = r_out.mode_now;
    assign o_persist_write  = r_out.persist_write;
    assign o_persist_value  = r_out.persist_value;

endmodule

// File: rtl/kcl_core.sv
module kcl_core
    import kcl_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    input  logic             i_step,
    input  logic [7:0]       i_key,
    output t_res             o_res
);

    logic [CFG_W-1:0] r_default_pin;
    t_mode            r_mode,  n_mode;
    logic [2:0]       r_cnt,   n_cnt;
    t_pin             r_entry, n_entry;
    t_pin             r_pin,   n_pin;
    logic             r_lock,  n_lock;
    t_event           n_event;
    logic             n_write;
    t_pin             shifted;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_pin <= DEFAULT_PIN_RST;
            r_mode        <= MODE_NORMAL;
            r_cnt         <= '0;
            r_entry       <= '0;
            r_pin         <= PIN_W'(DEFAULT_PIN_RST);
            r_lock        <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_default_pin <= i_cfg_wr_data;
            end
            if (i_step) begin
                r_mode  <= n_mode;
                r_cnt   <= n_cnt;
                r_entry <= n_entry;
                r_pin   <= n_pin;
                r_lock  <= n_lock;
            end
        end
    end

    assign shifted = PIN_W'({r_entry, i_key});

    always_comb begin
        n_mode  = r_mode;
        n_cnt   = r_cnt;
        n_entry = r_entry;
        n_pin   = r_pin;
        n_lock  = r_lock;
        n_event = EV_IGNORED;
        n_write = 1'b0;
        if (i_key == KEY_CLEAR) begin
            n_cnt   = '0;
            n_entry = '0;
            n_event = EV_CLEARED;
        end else if (i_key == KEY_CHANGE) begin
            if (r_mode == MODE_NORMAL) begin
                n_cnt   = '0;
                n_entry = '0;
                n_mode  = MODE_VERIFY;
                n_event = EV_CHANGE;
            end
        end else if (i_key >= KEY_ZERO && i_key <= KEY_NINE) begin
            n_entry = shifted;
            n_cnt   = r_cnt + 3'd1;
            n_event = EV_DIGIT;
            if (r_cnt == CNT_LAST) begin
                // full entry: act on it, then drop the buffer
                case (r_mode)
                    MODE_VERIFY: begin
                        if (shifted == r_pin) begin
                            n_mode  = MODE_NEWPIN;
                            n_event = EV_OLD_OK;
                        end else begin
                            n_lock  = 1'b0;
                            n_mode  = MODE_NORMAL;
                            n_event = EV_OLD_WRONG;
                        end
                    end
                    MODE_NEWPIN: begin
                        n_pin   = shifted;
                        n_write = 1'b1;
                        n_mode  = MODE_NORMAL;
                        n_event = EV_NEW_SAVED;
                    end
                    default: begin
                        if (shifted == PIN_ZEROS) begin
                            n_pin   = PIN_W'(r_default_pin);
                            n_write = 1'b1;
                            n_event = EV_RESTORED;
                        end else if (shifted == r_pin) begin
                            n_lock  = 1'b1;
                            n_event = EV_OPEN;
                        end else begin
                            n_lock  = 1'b0;
                            n_event = EV_REJECT;
                        end
                    end
                endcase
                n_cnt   = '0;
                n_entry = '0;
            end
        end
    end

    always_comb begin
        o_res.event_res      = n_event;
        o_res.lock_open      = n_lock;
        o_res.digits_entered = n_cnt;
        o_res.mode_now       = n_mode;
        o_res.persist_write  = n_write;
        o_res.persist_value  = 32'(n_pin);
    end

endmodule

// File: tb/keypad_code_lock_controller_unit_tb.sv
`timescale 1ns / 100ps

module keypad_code_lock_controller_unit_tb
    import kcl_pkg::*;
;

    localparam int LIVE_KEYS_PER_PHASE = 250;
    localparam int NUM_PHASES          = 7;

    localparam logic [7:0] DIR_KEYS [25] = '{
        8'h00, 8'hFF, 8'h3A,
        "1", "2", "3", "4",
        "9", "9", "9", "9",
        KEY_CLEAR, KEY_CHANGE, KEY_CHANGE, "5", KEY_CLEAR,
        "1", "2", "3", "4",
        KEY_CHANGE,
        KEY_ZERO, KEY_ZERO, KEY_ZERO, KEY_ZERO
    };

    // Tracks lock state per accepted key and holds the results still owed.
    class keypad_lock_tracker;
        t_mode       mode_q;
        int          count_q;
        t_pin        entry_q;
        t_pin        stored_q;
        logic        lock_q;
        logic [31:0] dflt_q;
        t_res        results_due[$];
        int          fail_cnt;

        function new();
            dflt_q   = DEFAULT_PIN_RST;
            mode_q   = MODE_NORMAL;
            count_q  = 0;
            entry_q  = '0;
            stored_q = t_pin'(DEFAULT_PIN_RST);
            lock_q   = 1'b0;
            fail_cnt = 0;
        endfunction

        function void set_default(logic [31:0] v);
            dflt_q = v;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void take_key(logic [7:0] key);
            t_res   r;
            t_event ev;
            logic   wr;
            ev = EV_IGNORED;
            wr = 1'b0;
            if (key == KEY_CLEAR) begin
                count_q = 0;
                entry_q = '0;
                ev      = EV_CLEARED;
            end else if (key == KEY_CHANGE) begin
                if (mode_q == MODE_NORMAL) begin
                    count_q = 0;
                    entry_q = '0;
                    mode_q  = MODE_VERIFY;
                    ev      = EV_CHANGE;
                end
            end else if (key >= KEY_ZERO && key <= KEY_NINE) begin
                entry_q = (entry_q << 8) | t_pin'(key);
                count_q++;
                ev = EV_DIGIT;
                if (count_q >= PIN_DIGITS) begin
                    if (mode_q == MODE_VERIFY) begin
                        if (entry_q == stored_q) begin
                            mode_q = MODE_NEWPIN;
                            ev     = EV_OLD_OK;
                        end else begin
                            lock_q = 1'b0;
                            mode_q = MODE_NORMAL;
                            ev     = EV_OLD_WRONG;
                        end
                    end else if (mode_q == MODE_NEWPIN) begin
                        stored_q = entry_q;
                        wr       = 1'b1;
                        mode_q   = MODE_NORMAL;
                        ev       = EV_NEW_SAVED;
                    end else if (entry_q == PIN_ZEROS) begin
                        // reset code: lock position stays as it is
                        stored_q = t_pin'(dflt_q);
                        wr       = 1'b1;
                        ev       = EV_RESTORED;
                    end else if (entry_q == stored_q) begin
                        lock_q = 1'b1;
                        ev     = EV_OPEN;
                    end else begin
                        lock_q = 1'b0;
                        ev     = EV_REJECT;
                    end
                    count_q = 0;
                    entry_q = '0;
                end
            end
            r.event_res      = ev;
            r.lock_open      = lock_q;
            r.digits_entered = 3'(count_q);
            r.mode_now       = mode_q;
            r.persist_write  = wr;
            r.persist_value  = 32'(stored_q);
            results_due.push_back(r);
        endfunction

        function void match_result(t_res got);
            t_res want;
            logic bad;
            if (results_due.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display({"%0t: result with none owed: ",
                              "ev=%0d lock=%0d cnt=%0d mode=%0d wr=%0d pin=%h"},
                             $realtime, got.event_res, got.lock_open, got.digits_entered,
                             got.mode_now, got.persist_write, got.persist_value);
                return;
            end
            want = results_due.pop_front();
            bad = (got.event_res !== want.event_res)
               || (got.lock_open !== want.lock_open)
               || (got.digits_entered !== want.digits_entered)
               || (got.mode_now !== want.mode_now)
               || (got.persist_write !== want.persist_write)
               || (got.persist_value !== want.persist_value);
            if (bad) begin
                fail_cnt++;
                if (fail_cnt <= 10) begin
                    $display("%0t: mismatch exp ev=%0d lock=%0d cnt=%0d mode=%0d wr=%0d pin=%h",
                             $realtime, want.event_res, want.lock_open, want.digits_entered,
                             want.mode_now, want.persist_write, want.persist_value);
                    $display("%0t:          got ev=%0d lock=%0d cnt=%0d mode=%0d wr=%0d pin=%h",
                             $realtime, got.event_res, got.lock_open, got.digits_entered,
                             got.mode_now, got.persist_write, got.persist_value);
                end
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = '0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_key_code    = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic [3:0]  o_event_res;
    logic        o_lock_open;
    logic [2:0]  o_digits_entered;
    logic [1:0]  o_mode_now;
    logic        o_persist_write;
    logic [31:0] o_persist_value;

    keypad_lock_tracker tracker;
    int burst_left = 0;
    int live_keys  = 0;
    int stall_left = 0;
    bit stall_now  = 1'b0;

    keypad_code_lock_controller_unit u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_key_code       (i_key_code),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_event_res      (o_event_res),
        .o_lock_open      (o_lock_open),
        .o_digits_entered (o_digits_entered),
        .o_mode_now       (o_mode_now),
        .o_persist_write  (o_persist_write),
        .o_persist_value  (o_persist_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #6_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: alternate free and stalled runs, with an occasional long calm stretch.
    always @(posedge i_clk) begin : rx_side
        t_res got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.event_res      = t_event'(o_event_res);
            got.lock_open      = o_lock_open;
            got.digits_entered = o_digits_entered;
            got.mode_now       = t_mode'(o_mode_now);
            got.persist_write  = o_persist_write;
            got.persist_value  = o_persist_value;
            tracker.match_result(got);
        end
        if (stall_left == 0) begin
            if (stall_now) begin
                stall_now  = 1'b0;
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                         : $urandom_range(1, 20);
            end else begin
                stall_now  = 1'b1;
                stall_left = $urandom_range(1, 12);
            end
        end
        stall_left--;
        i_out_stall <= stall_now;
    end

    function automatic logic [7:0] rand_digit();
        return KEY_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // Append the stored PIN; swap any non-digit byte for a random digit.
    function automatic void add_stored(ref logic [7:0] q[$]);
        logic [7:0] b;
        for (int i = PIN_DIGITS - 1; i >= 0; i--) begin
            b = tracker.stored_q[8*i +: 8];
            if (b < KEY_ZERO || b > KEY_NINE)
                b = rand_digit();
            q.push_back(b);
        end
    endfunction

    function automatic void add_digits(ref logic [7:0] q[$], input int n, input bit zeros);
        for (int i = 0; i < n; i++)
            q.push_back(zeros ? KEY_ZERO : rand_digit());
    endfunction

    task automatic send_key(input logic [7:0] k);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_key_code <= k;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.take_key(k);
        burst_left--;
        if (k == KEY_CLEAR || k == KEY_CHANGE || (k >= KEY_ZERO && k <= KEY_NINE))
            live_keys++;
    endtask

    // Build one key sequence from the current lock state, then transfer it.
    task automatic run_sequence();
        logic [7:0] seq[$];
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 20) begin
            add_stored(seq);
        end else if (kind < 32) begin
            add_digits(seq, PIN_DIGITS, 1'b0);
        end else if (kind < 40) begin
            add_digits(seq, PIN_DIGITS, 1'b1);
        end else if (kind < 60) begin
            seq.push_back(KEY_CHANGE);
            add_stored(seq);
            add_digits(seq, PIN_DIGITS, $urandom_range(0, 9) == 0);
        end else if (kind < 68) begin
            seq.push_back(KEY_CHANGE);
            add_digits(seq, PIN_DIGITS, 1'b0);
        end else if (kind < 76) begin
            add_digits(seq, $urandom_range(1, PIN_DIGITS - 1), 1'b0);
            seq.push_back(KEY_CLEAR);
        end else if (kind < 84) begin
            seq.push_back(KEY_CHANGE);
            add_digits(seq, 2, 1'b0);
            seq.push_back(KEY_CLEAR);
            add_stored(seq);
            seq.push_back(KEY_CHANGE);
            add_digits(seq, PIN_DIGITS, 1'b0);
        end else begin
            repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 19) == 0)
            seq.insert($urandom_range(0, seq.size()), 8'($urandom_range(0, 255)));
        foreach (seq[i]) send_key(seq[i]);
    endtask

    initial begin
        logic [31:0] cfg_val;
        tracker = new();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_KEYS[i]) send_key(DIR_KEYS[i]);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph > 0) begin
                // drain, then change the restore PIN while nothing is in flight
                i_in_valid <= 1'b0;
                while (tracker.pending() != 0) @(posedge i_clk);
                repeat (4) @(posedge i_clk);
                case (ph)
                    1:       cfg_val = 32'h0000_0000;
                    2:       cfg_val = 32'hFFFF_FFFF;
                    3:       cfg_val = {rand_digit(), rand_digit(), rand_digit(), rand_digit()};
                    4:       cfg_val = $urandom;
                    5:       cfg_val = 32'h3939_3939;
                    default: cfg_val = 32'h3030_3030;
                endcase
                i_cfg_wr_en   <= 1'b1;
                i_cfg_wr_data <= cfg_val;
                @(posedge i_clk);
                i_cfg_wr_en <= 1'b0;
                tracker.set_default(cfg_val);
            end
            live_keys = 0;
            while (live_keys < LIVE_KEYS_PER_PHASE) run_sequence();
        end

        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (tracker.fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: keypad_code_lock_controller_unit.f
rtl/kcl_pkg.sv
rtl/kcl_core.sv
rtl/keypad_code_lock_controller_unit.sv
tb/keypad_code_lock_controller_unit_tb.sv
